// File: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared codes, default sizes and the per-cycle command seen by every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // Default configuration.
  localparam int unsigned DefaultDepth      = 16;
  localparam int unsigned DefaultPrioBits   = 8;

  // Fixed field widths of the stream payloads.
  localparam int unsigned ValueW     = 32;
  localparam int unsigned PrioInW    = 8;
  localparam int unsigned FillW      = 5;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned InDataW    = 40;
  localparam int unsigned OutDataW   = 80;

  // Request kinds carried on the input tuser bit.
  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Command broadcast to the cell chain for one cycle.
  typedef struct packed {
    logic ins;
    logic rem;
  } spq_cmd_t;

endpackage

`default_nettype wire

// File: hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// Stable priority queue cell
// Holds one slot of the sorted queue and trades entries with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned PRIO_W = DefaultPrioBits
) (
  input  wire logic              clk_i,
  input  wire spq_cmd_t          cmd_i,
  input  wire logic              live_i,
  input  wire logic [ValueW-1:0] new_value_i,
  input  wire logic [PRIO_W-1:0] new_prio_i,
  input  wire logic              prev_before_i,
  input  wire logic [ValueW-1:0] prev_value_i,
  input  wire logic [PRIO_W-1:0] prev_prio_i,
  input  wire logic [ValueW-1:0] next_value_i,
  input  wire logic [PRIO_W-1:0] next_prio_i,
  output logic                   before_o,
  output logic [ValueW-1:0]      value_o,
  output logic [PRIO_W-1:0]      prio_o,
  output logic [ValueW-1:0]      value_next_o
);

  logic [ValueW-1:0] value_q, value_d;
  logic [PRIO_W-1:0] prio_q, prio_d;

  // The new entry belongs at or before this slot when the slot is empty or
  // holds a strictly larger priority, so equal priorities keep arrival order.
  assign before_o = !live_i || (prio_q > new_prio_i);

  // Insert shifts toward the tail, removal shifts toward the head.
  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    if (cmd_i.ins && before_o) begin
      if (prev_before_i) begin
        value_d = prev_value_i;
        prio_d  = prev_prio_i;
      end else begin
        value_d = new_value_i;
        prio_d  = new_prio_i;
      end
    end else if (cmd_i.rem) begin
      value_d = next_value_i;
      prio_d  = next_prio_i;
    end
  end

  // Slot storage, no reset: slots beyond the fill count are never read.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o      = value_q;
  assign prio_o       = prio_q;
  assign value_next_o = value_d;

endmodule

`default_nettype wire

// File: hdl/stable_priority_queue.sv
// The result of a request is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle while the result output is being taken;
// every cell of the chain shifts in the same cycle, so no step is iterative.
// Reset clears the fill count and the result valid; slot contents are left
// as they are and are never read before being written.
// ----------------------------------------------------------------------------
// Stable priority queue
// Sorted bounded queue built as a chain of cells, lowest priority at the head.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH         = DefaultDepth,
  parameter int unsigned PRIORITY_BITS = DefaultPrioBits
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: [31:0] item_value, [39:32] item_priority
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // tuser: [0] action
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // tdata: [31:0] taken_value, [32] taken_valid, [64:33] front_value,
  //        [65] queue_empty, [70:66] fill_count, [72:71] status, rest zero
  output logic [OutDataW-1:0]      m_axis_tdata
);

  localparam int unsigned CountW = $clog2(DEPTH + 1);
  localparam int unsigned PadW   = OutDataW - (2 * ValueW + 2 + FillW + StatusW);

  logic [CountW-1:0]        count_q, count_d;
  logic                     out_valid_q;
  logic [OutDataW-1:0]      out_data_q, out_data_d;
  logic                     accept;
  logic                     full, empty;
  spq_cmd_t                 cmd;
  status_e                  status;
  logic [ValueW-1:0]        new_value;
  logic [PRIORITY_BITS-1:0] new_prio;
  logic [ValueW-1:0]        front_value;

  logic [DEPTH-1:0]         ins_here;
  logic [ValueW-1:0]        cell_value [DEPTH];
  logic [PRIORITY_BITS-1:0] cell_prio  [DEPTH];
  logic [ValueW-1:0]        cell_value_next [DEPTH];

  // A request enters whenever the result register is free or being drained.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign new_value = s_axis_tdata[ValueW-1:0];
  assign new_prio  = PRIORITY_BITS'(s_axis_tdata[ValueW +: PrioInW]);
  assign full      = (count_q == CountW'(DEPTH));
  assign empty     = (count_q == '0);

  // Decode the request into a chain command and a status.
  always_comb begin
    cmd     = '0;
    status  = ST_OK;
    count_d = count_q;
    if (accept) begin
      if (action_e'(s_axis_tuser) == ACT_INSERT) begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          count_d = count_q + CountW'(1);
        end
      end else begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cmd.rem = 1'b1;
          count_d = count_q - CountW'(1);
        end
      end
    end
  end

  // Cell chain: slot 0 is the head.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     prev_before;
    logic [ValueW-1:0]        prev_value, next_value;
    logic [PRIORITY_BITS-1:0] prev_prio, next_prio;
    logic                     live;

    assign live = (CountW'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_before = 1'b0;
      assign prev_value  = new_value;
      assign prev_prio   = new_prio;
    end else begin : g_body
      assign prev_before = ins_here[i-1];
      assign prev_value  = cell_value[i-1];
      assign prev_prio   = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_value = cell_value[i];
      assign next_prio  = cell_prio[i];
    end else begin : g_mid
      assign next_value = cell_value[i+1];
      assign next_prio  = cell_prio[i+1];
    end

    spq_cell #(
      .PRIO_W (PRIORITY_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .live_i        (live),
      .new_value_i   (new_value),
      .new_prio_i    (new_prio),
      .prev_before_i (prev_before),
      .prev_value_i  (prev_value),
      .prev_prio_i   (prev_prio),
      .next_value_i  (next_value),
      .next_prio_i   (next_prio),
      .before_o      (ins_here[i]),
      .value_o       (cell_value[i]),
      .prio_o        (cell_prio[i]),
      .value_next_o  (cell_value_next[i])
    );
  end

  // Head after this step, all ones when the queue ends up empty.
  assign front_value = (count_d == '0) ? {ValueW{1'b1}} : cell_value_next[0];

  // Assemble the result.
  always_comb begin
    out_data_d = {
      {PadW{1'b0}},
      status,
      FillW'(count_d),
      (count_d == '0),
      front_value,
      cmd.rem,
      (cmd.rem ? cell_value[0] : {ValueW{1'b0}})
    };
  end

  // Fill count and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Stable priority queue testbench
// Sends insert and remove requests over the input stream with random gaps.
// Back-pressures the result stream at random. Every result is checked field by
// field against a sorted-queue predictor that is updated as each request is
// accepted.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned Depth          = DefaultDepth;
  localparam int unsigned PrioBits       = DefaultPrioBits;
  localparam int unsigned RandomRequests = 1200;
  localparam int unsigned MaxWait        = 18;
  localparam int unsigned StallLimit     = 400;
  localparam int unsigned DrainCycles    = 8;

  typedef struct {
    action_e             act;
    logic [ValueW-1:0]   value;
    logic [PrioInW-1:0]  prio;
  } request_t;

  typedef struct {
    logic [ValueW-1:0]   taken_value;
    logic                taken_valid;
    logic [ValueW-1:0]   front_value;
    logic                queue_empty;
    logic [FillW-1:0]    fill_count;
    status_e             status;
  } outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  // Predicted queue contents, head in slot 0.
  logic [ValueW-1:0]   slot_value [Depth];
  logic [PrioInW-1:0]  slot_prio  [Depth];
  int                  slot_count = 0;

  request_t            request_q[$];
  outcome_t            outcome_q[$];
  request_t            current_req;

  bit                  req_taken = 1'b0;
  bit                  tx_busy = 1'b0;
  bit                  tx_calm = 1'b0;
  bit                  rx_calm = 1'b0;
  int unsigned         tx_wait = 0;
  int unsigned         rx_wait = 0;
  int unsigned         stall_cycles = 0;
  int unsigned         mismatches = 0;

  stable_priority_queue uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // Applies one request to the predicted queue and returns the result it causes.
  function automatic outcome_t serve_request(request_t req);
    outcome_t          res;
    logic [PrioInW-1:0] prio;
    int                pos;
    res.taken_value = '0;
    res.taken_valid = 1'b0;
    res.status      = ST_OK;
    prio = req.prio & PrioInW'((1 << PrioBits) - 1);
    if (req.act == ACT_INSERT) begin
      if (slot_count >= Depth) begin
        res.status = ST_FULL;
      end else begin
        // A new entry goes behind every entry of lower or equal priority.
        pos = 0;
        while (pos < slot_count && slot_prio[pos] <= prio) pos++;
        for (int i = slot_count; i > pos; i--) begin
          slot_value[i] = slot_value[i-1];
          slot_prio[i]  = slot_prio[i-1];
        end
        slot_value[pos] = req.value;
        slot_prio[pos]  = prio;
        slot_count++;
      end
    end else begin
      if (slot_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.taken_value = slot_value[0];
        res.taken_valid = 1'b1;
        for (int i = 1; i < slot_count; i++) begin
          slot_value[i-1] = slot_value[i];
          slot_prio[i-1]  = slot_prio[i];
        end
        slot_count--;
      end
    end
    res.front_value = (slot_count != 0) ? slot_value[0] : '1;
    res.queue_empty = (slot_count == 0);
    res.fill_count  = FillW'(slot_count);
    return res;
  endfunction

  function automatic void check_field(string name, logic [ValueW-1:0] want,
                                      logic [ValueW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      mismatches++;
    end
  endfunction

  // Wait before the next transfer; calm stretches run with no gaps at all.
  function automatic int unsigned draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, MaxWait);
  endfunction

  function automatic void add_request(action_e act, logic [ValueW-1:0] value,
                                      logic [PrioInW-1:0] prio);
    request_t req;
    req.act   = act;
    req.value = value;
    req.prio  = prio;
    request_q.push_back(req);
  endfunction

  // Request driver: presents queued requests with random gaps between them.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_taken) begin
        req_taken = 1'b0;
        tx_busy   = 1'b0;
      end
      if (!tx_busy) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (request_q.size() != 0) begin
          current_req = request_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {current_req.prio, current_req.value};
          s_axis_tuser  <= current_req.act;
          tx_busy = 1'b1;
          if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
          tx_wait = draw_wait(tx_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: after each accepted result, holds off tready for a random wait.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on accepted requests and checks accepted results.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        outcome_q.push_back(serve_request(current_req));
        req_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcome_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          check_field("taken_value", want.taken_value, m_axis_tdata[31:0]);
          check_field("taken_valid", 32'(want.taken_valid), 32'(m_axis_tdata[32]));
          check_field("front_value", want.front_value, m_axis_tdata[64:33]);
          check_field("queue_empty", 32'(want.queue_empty), 32'(m_axis_tdata[65]));
          check_field("fill_count", 32'(want.fill_count), 32'(m_axis_tdata[70:66]));
          check_field("status", 32'(want.status), 32'(m_axis_tdata[72:71]));
          check_field("padding", 32'd0, 32'(m_axis_tdata[OutDataW-1:73]));
        end
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_wait = draw_wait(rx_calm);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  // Watchdog: ends the run when no request or result moves for too long.
  initial begin
    wait (rst_ni === 1'b1);
    while (stall_cycles < StallLimit) @(negedge clk_i);
    $display("testbench failed");
    $finish;
  end

  // Stimulus and end of test.
  initial begin
    int unsigned       remaining;
    int unsigned       phase_len;
    int unsigned       ins_pct;
    logic [ValueW-1:0] value;
    logic [PrioInW-1:0] prio;
    action_e           act;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_INSERT;
    m_axis_tready = 1'b0;

    // Directed: removal from an empty queue, then a head value of all ones.
    add_request(ACT_REMOVE, 32'h1234_5678, 8'hFF);
    add_request(ACT_INSERT, 32'hFFFF_FFFF, 8'd0);
    add_request(ACT_REMOVE, 32'hFFFF_FFFF, 8'd0);

    // Fill to capacity with extreme values, extreme priorities and ties.
    add_request(ACT_INSERT, 32'h7FFF_FFFF, 8'd255);
    add_request(ACT_INSERT, 32'h8000_0000, 8'd0);
    add_request(ACT_INSERT, 32'h0000_0000, 8'd128);
    add_request(ACT_INSERT, 32'h0000_0001, 8'd128);
    add_request(ACT_INSERT, 32'h0000_0002, 8'd128);
    add_request(ACT_INSERT, 32'hFFFF_FFFF, 8'd255);
    add_request(ACT_INSERT, 32'h5555_5555, 8'd0);
    add_request(ACT_INSERT, 32'hAAAA_AAAA, 8'h55);
    for (int k = 0; k < Depth - 8; k++) begin
      case (k % 4)
        0: prio = 8'd0;
        1: prio = 8'd128;
        2: prio = 8'd255;
        default: prio = 8'hAA;
      endcase
      add_request(ACT_INSERT, $urandom, prio);
    end

    // Insert into a full queue is refused; then take a few from the head.
    add_request(ACT_INSERT, 32'h0000_007B, 8'd0);
    add_request(ACT_REMOVE, $urandom, PrioInW'($urandom));
    add_request(ACT_REMOVE, $urandom, PrioInW'($urandom));
    add_request(ACT_REMOVE, $urandom, PrioInW'($urandom));

    // Random phases that lean toward filling, mixing or draining the queue.
    remaining = RandomRequests;
    while (remaining > 0) begin
      phase_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0: ins_pct = 85;
        1: ins_pct = 50;
        default: ins_pct = 15;
      endcase
      for (int k = 0; k < phase_len && remaining > 0; k++) begin
        case ($urandom_range(0, 5))
          0: value = 32'h8000_0000;
          1: value = 32'h7FFF_FFFF;
          2: value = 32'hFFFF_FFFF;
          default: value = $urandom;
        endcase
        // Narrow priority sets make ties common so arrival order is tested.
        case ($urandom_range(0, 3))
          0: prio = PrioInW'($urandom_range(0, 255));
          1: prio = PrioInW'($urandom_range(0, 3));
          2: prio = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
          default: prio = PrioInW'($urandom_range(100, 103));
        endcase
        act = ($urandom_range(0, 99) < ins_pct) ? ACT_INSERT : ACT_REMOVE;
        add_request(act, value, prio);
        remaining--;
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to go out and every result to come back.
    while (request_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);

    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
